/* rtl/core/rmq_pkg.sv */
// ----------------------------------------------------------------------------
// rmq_pkg: shared constants, types and helpers
// Widths, pipeline depths and saturation helpers for the rotation matrix to
// quaternion pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

   // fixed point format
   localparam int FRAC_BITS = 16;
   localparam int Q_W       = 18;
   localparam int S_W       = Q_W + 1;             // sum/difference of two elements
   localparam int T_W       = Q_W + 2;             // trace of three elements
   localparam int ARG_W     = (FRAC_BITS > 17) ? FRAC_BITS + 3 : 21;

   // square root sizing
   localparam int RAD_RAW   = ARG_W - 1 + FRAC_BITS;
   localparam int RAD_W     = RAD_RAW + (RAD_RAW % 2);
   localparam int ROOT_W    = RAD_W / 2;
   localparam int SQR_W     = ROOT_W + 3;
   localparam int SQ_STEP   = 2;
   localparam int SQ_ST     = (ROOT_W + SQ_STEP - 1) / SQ_STEP;

   // divider sizing
   localparam int D_W       = ROOT_W + 1;
   localparam int NUM_W     = S_W + FRAC_BITS;
   localparam int HI_W      = NUM_W - Q_W;
   localparam int DV_W      = ((HI_W > D_W) ? HI_W : D_W) + 1;
   localparam int DV_STEP   = 2;
   localparam int DV_ST     = (Q_W + DV_STEP - 1) / DV_STEP;
   localparam int DIV_LAT   = DV_ST + 1;

   // request to result, in cycles
   localparam int LATENCY   = 3 + SQ_ST + DIV_LAT;

   // branch codes
   localparam logic [1:0] BR_TRACE = 2'd0;
   localparam logic [1:0] BR_X     = 2'd1;
   localparam logic [1:0] BR_Y     = 2'd2;
   localparam logic [1:0] BR_Z     = 2'd3;

   localparam logic signed [Q_W-1:0] QMAX = {1'b0, {(Q_W-1){1'b1}}};
   localparam logic signed [Q_W-1:0] QMIN = {1'b1, {(Q_W-1){1'b0}}};

   typedef logic signed [Q_W-1:0] elem_type;
   typedef logic signed [S_W-1:0] sum_type;

   // sideband through the square root stages
   typedef struct packed {
      logic [1:0] branch;
      logic       invalid;
      sum_type    s0;
      sum_type    s1;
      sum_type    s2;
   } sq_side_type;

   // sideband through the divider stages
   typedef struct packed {
      logic [1:0] branch;
      logic       invalid;
      elem_type   lead;
   } dv_side_type;

   // leading component: root / 2, clipped to the positive limit
   function automatic elem_type lead_sat(input logic [ROOT_W-1:0] root);
      logic [ROOT_W-1:0] half;
      half = root >> 1;
      if (half > ROOT_W'(QMAX)) begin
         return QMAX;
      end
      return Q_W'(half);
   endfunction

endpackage

`default_nettype wire

/* rtl/core/rotation_matrix_to_quaternion_unit.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit: 3x3 rotation matrix to quaternion
// Fully pipelined Q2.16 conversion with a pipelined root and three dividers.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive the nine matrix elements on req_* and raise start.
//   A request is taken at each rising edge where start is high and busy is
//   low. busy stays low: the pipeline takes one matrix every cycle.
//   Result channel: rsp_valid is high for exactly one cycle with the
//   quaternion, branch_taken and invalid on the rsp_* ports. The receiver
//   cannot stall the block and must take each result in that cycle.
//   Pipeline, from request to result: two setup stages, SQ_STEP root bits per
//   stage of the square root (9), one divider setup stage plus DV_STEP
//   quotient bits per stage (9), and the output register. Throughput: one
//   result per cycle. Results leave in request order.
//   Reset: synchronous, clears all valid bits; requests in flight are dropped
//   and no result appears before the next request reaches the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rotation_matrix_to_quaternion_unit import rmq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic signed [Q_W-1:0] req_row0_col0,
   input  logic signed [Q_W-1:0] req_row0_col1,
   input  logic signed [Q_W-1:0] req_row0_col2,
   input  logic signed [Q_W-1:0] req_row1_col0,
   input  logic signed [Q_W-1:0] req_row1_col1,
   input  logic signed [Q_W-1:0] req_row1_col2,
   input  logic signed [Q_W-1:0] req_row2_col0,
   input  logic signed [Q_W-1:0] req_row2_col1,
   input  logic signed [Q_W-1:0] req_row2_col2,
   output logic                  rsp_valid,
   output logic signed [Q_W-1:0] rsp_quat_w,
   output logic signed [Q_W-1:0] rsp_quat_x,
   output logic signed [Q_W-1:0] rsp_quat_y,
   output logic signed [Q_W-1:0] rsp_quat_z,
   output logic [1:0]            rsp_branch_taken,
   output logic                  rsp_invalid
);

   localparam logic signed [ARG_W-1:0] ARG_ONE = ARG_W'(1) << FRAC_BITS;

   assign busy = 1'b0;

   // ---------------- stage A: trace and branch pick ----------------
   elem_type         ma_ff [3][3];
   logic signed [T_W-1:0] trace_ff;
   logic [1:0]       bra_ff;
   logic             va_ff;

   logic signed [T_W-1:0] trace_in;
   logic [1:0]       bra_in;
   elem_type         diag_max;

   always_comb begin
      trace_in = T_W'(req_row0_col0) + T_W'(req_row1_col1) + T_W'(req_row2_col2);
      bra_in   = BR_X;
      diag_max = req_row0_col0;
      if (req_row1_col1 > req_row0_col0) begin
         bra_in   = BR_Y;
         diag_max = req_row1_col1;
      end
      if (req_row2_col2 > diag_max) begin
         bra_in = BR_Z;
      end
      if (trace_in > 0) begin
         bra_in = BR_TRACE;
      end
   end

   always_ff @(posedge clock) begin
      ma_ff[0][0] <= req_row0_col0;
      ma_ff[0][1] <= req_row0_col1;
      ma_ff[0][2] <= req_row0_col2;
      ma_ff[1][0] <= req_row1_col0;
      ma_ff[1][1] <= req_row1_col1;
      ma_ff[1][2] <= req_row1_col2;
      ma_ff[2][0] <= req_row2_col0;
      ma_ff[2][1] <= req_row2_col1;
      ma_ff[2][2] <= req_row2_col2;
      trace_ff    <= trace_in;
      bra_ff      <= bra_in;
   end

   // ---------------- stage B: root argument and numerators ----------------
   logic signed [ARG_W-1:0] arg_ff;
   sum_type          s0_ff, s1_ff, s2_ff;
   logic [1:0]       brb_ff;
   logic             vb_ff;

   logic signed [ARG_W-1:0] arg_in;
   sum_type          s0_in, s1_in, s2_in;

   always_comb begin
      unique case (bra_ff)
         BR_TRACE: begin
            arg_in = ARG_W'(trace_ff) + ARG_ONE;
            s0_in  = S_W'(ma_ff[1][2]) - S_W'(ma_ff[2][1]);
            s1_in  = S_W'(ma_ff[2][0]) - S_W'(ma_ff[0][2]);
            s2_in  = S_W'(ma_ff[0][1]) - S_W'(ma_ff[1][0]);
         end
         BR_X: begin
            arg_in = ARG_W'(ma_ff[0][0]) - ARG_W'(ma_ff[1][1]) - ARG_W'(ma_ff[2][2])
                     + ARG_ONE;
            s0_in  = S_W'(ma_ff[1][2]) - S_W'(ma_ff[2][1]);
            s1_in  = S_W'(ma_ff[1][0]) + S_W'(ma_ff[0][1]);
            s2_in  = S_W'(ma_ff[0][2]) + S_W'(ma_ff[2][0]);
         end
         BR_Y: begin
            arg_in = ARG_W'(ma_ff[1][1]) - ARG_W'(ma_ff[2][2]) - ARG_W'(ma_ff[0][0])
                     + ARG_ONE;
            s0_in  = S_W'(ma_ff[2][0]) - S_W'(ma_ff[0][2]);
            s1_in  = S_W'(ma_ff[2][1]) + S_W'(ma_ff[1][2]);
            s2_in  = S_W'(ma_ff[1][0]) + S_W'(ma_ff[0][1]);
         end
         default: begin
            arg_in = ARG_W'(ma_ff[2][2]) - ARG_W'(ma_ff[0][0]) - ARG_W'(ma_ff[1][1])
                     + ARG_ONE;
            s0_in  = S_W'(ma_ff[0][1]) - S_W'(ma_ff[1][0]);
            s1_in  = S_W'(ma_ff[0][2]) + S_W'(ma_ff[2][0]);
            s2_in  = S_W'(ma_ff[1][2]) + S_W'(ma_ff[2][1]);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      arg_ff <= arg_in;
      s0_ff  <= s0_in;
      s1_ff  <= s1_in;
      s2_ff  <= s2_in;
      brb_ff <= bra_ff;
   end

   // ---------------- square root stages ----------------
   logic             bad;
   logic [RAD_W-1:0] rad;
   logic [ROOT_W-1:0] root;
   sq_side_type      sq_side_in;

   always_comb begin
      bad = (arg_ff <= 0);
      rad = bad ? '0 : RAD_W'({arg_ff[ARG_W-2:0], {FRAC_BITS{1'b0}}});
      sq_side_in.branch  = brb_ff;
      sq_side_in.invalid = bad;
      sq_side_in.s0      = s0_ff;
      sq_side_in.s1      = s1_ff;
      sq_side_in.s2      = s2_ff;
   end

   rmq_sqrt u_sqrt (
      .clock (clock),
      .rad   (rad),
      .root  (root)
   );

   sq_side_type      sq_side_ff [SQ_ST];
   logic [SQ_ST-1:0] sq_vld_ff;

   always_ff @(posedge clock) begin
      sq_side_ff[0] <= sq_side_in;
      for (int i = 1; i < SQ_ST; i++) begin
         sq_side_ff[i] <= sq_side_ff[i-1];
      end
   end

   // ---------------- divider stages ----------------
   elem_type d0, d1, d2;
   sq_side_type sq_last;
   dv_side_type dv_side_in;

   always_comb begin
      sq_last            = sq_side_ff[SQ_ST-1];
      dv_side_in.branch  = sq_last.branch;
      dv_side_in.invalid = sq_last.invalid;
      dv_side_in.lead    = lead_sat(root);
   end

   rmq_div u_div0 (.clock(clock), .s(sq_last.s0), .root(root), .q(d0));
   rmq_div u_div1 (.clock(clock), .s(sq_last.s1), .root(root), .q(d1));
   rmq_div u_div2 (.clock(clock), .s(sq_last.s2), .root(root), .q(d2));

   dv_side_type        dv_side_ff [DIV_LAT];
   logic [DIV_LAT-1:0] dv_vld_ff;

   always_ff @(posedge clock) begin
      dv_side_ff[0] <= dv_side_in;
      for (int i = 1; i < DIV_LAT; i++) begin
         dv_side_ff[i] <= dv_side_ff[i-1];
      end
   end

   // ---------------- output placement ----------------
   dv_side_type dv_last;
   elem_type    qw_in, qx_in, qy_in, qz_in;

   always_comb begin
      dv_last = dv_side_ff[DIV_LAT-1];
      unique case (dv_last.branch)
         BR_TRACE: begin
            qw_in = dv_last.lead; qx_in = d0; qy_in = d1; qz_in = d2;
         end
         BR_X: begin
            qw_in = d0; qx_in = dv_last.lead; qy_in = d1; qz_in = d2;
         end
         BR_Y: begin
            qw_in = d0; qx_in = d2; qy_in = dv_last.lead; qz_in = d1;
         end
         default: begin
            qw_in = d0; qx_in = d1; qy_in = d2; qz_in = dv_last.lead;
         end
      endcase
      if (dv_last.invalid) begin
         qw_in = '0;
         qx_in = '0;
         qy_in = '0;
         qz_in = '0;
      end
   end

   elem_type   quat_w_ff, quat_x_ff, quat_y_ff, quat_z_ff;
   logic [1:0] branch_ff;
   logic       invalid_ff;
   logic       rsp_valid_ff;

   always_ff @(posedge clock) begin
      quat_w_ff  <= qw_in;
      quat_x_ff  <= qx_in;
      quat_y_ff  <= qy_in;
      quat_z_ff  <= qz_in;
      branch_ff  <= dv_last.branch;
      invalid_ff <= dv_last.invalid;
   end

   // valid bits travel beside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff        <= 1'b0;
         vb_ff        <= 1'b0;
         sq_vld_ff    <= '0;
         dv_vld_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         va_ff        <= start && !busy;
         vb_ff        <= va_ff;
         sq_vld_ff    <= {sq_vld_ff[SQ_ST-2:0], vb_ff};
         dv_vld_ff    <= {dv_vld_ff[DIV_LAT-2:0], sq_vld_ff[SQ_ST-1]};
         rsp_valid_ff <= dv_vld_ff[DIV_LAT-1];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_quat_w       = quat_w_ff;
   assign rsp_quat_x       = quat_x_ff;
   assign rsp_quat_y       = quat_y_ff;
   assign rsp_quat_z       = quat_z_ff;
   assign rsp_branch_taken = branch_ff;
   assign rsp_invalid      = invalid_ff;

   // ---------------- assertions ----------------
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_invalid |->
         (rsp_quat_w == 0) && (rsp_quat_x == 0) && (rsp_quat_y == 0) && (rsp_quat_z == 0))
      else $error("invalid result carries nonzero quaternion");

   a_invalid_branch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_invalid |-> (rsp_branch_taken != BR_TRACE))
      else $error("trace path flagged invalid");

   a_trace_w_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_branch_taken == BR_TRACE) |-> (rsp_quat_w > 0))
      else $error("trace path gave non-positive w");

endmodule

`default_nettype wire

/* rtl/core/rmq_sqrt.sv */
// ----------------------------------------------------------------------------
// rmq_sqrt: pipelined integer square root
// Restoring digit method, two result bits per stage; floor(sqrt(rad)).
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_sqrt import rmq_pkg::*; (
   input  logic              clock,
   input  logic [RAD_W-1:0]  rad,
   output logic [ROOT_W-1:0] root
);

   logic [RAD_W-1:0]  rad_ff  [SQ_ST];
   logic [SQR_W-1:0]  rem_ff  [SQ_ST];
   logic [ROOT_W-1:0] root_ff [SQ_ST];

   for (genvar g = 0; g < SQ_ST; g++) begin : g_stage
      logic [RAD_W-1:0]  rad_src;
      logic [SQR_W-1:0]  rem_src;
      logic [ROOT_W-1:0] root_src;
      logic [RAD_W-1:0]  rad_in;
      logic [SQR_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;
      logic [SQR_W-1:0]  trial;

      if (g == 0) begin : g_first
         assign rad_src  = rad;
         assign rem_src  = '0;
         assign root_src = '0;
      end else begin : g_next
         assign rad_src  = rad_ff[g-1];
         assign rem_src  = rem_ff[g-1];
         assign root_src = root_ff[g-1];
      end

      // two digit steps
      always_comb begin
         rad_in  = rad_src;
         rem_in  = rem_src;
         root_in = root_src;
         trial   = '0;
         for (int t = 0; t < SQ_STEP; t++) begin
            if (g * SQ_STEP + t < ROOT_W) begin
               rem_in = {rem_in[SQR_W-3:0], rad_in[RAD_W-1 -: 2]};
               rad_in = rad_in << 2;
               trial  = SQR_W'({root_in, 2'b01});
               if (rem_in >= trial) begin
                  rem_in  = rem_in - trial;
                  root_in = {root_in[ROOT_W-2:0], 1'b1};
               end else begin
                  root_in = {root_in[ROOT_W-2:0], 1'b0};
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         rad_ff[g]  <= rad_in;
         rem_ff[g]  <= rem_in;
         root_ff[g] <= root_in;
      end
   end

   assign root = root_ff[SQ_ST-1];

endmodule

`default_nettype wire

/* rtl/core/rmq_div.sv */
// ----------------------------------------------------------------------------
// rmq_div: pipelined scaled divide
// q = (s * 2^FRAC_BITS) / (2 * root), truncated toward zero and saturated.
// One setup stage, then two quotient bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_div import rmq_pkg::*; (
   input  logic              clock,
   input  sum_type           s,
   input  logic [ROOT_W-1:0] root,
   output elem_type          q
);

   logic [DV_W-1:0] rem_ff [DIV_LAT];
   logic [Q_W-1:0]  lo_ff  [DIV_LAT];
   logic [Q_W-1:0]  quo_ff [DIV_LAT];
   logic [DV_W-1:0] d_ff   [DIV_LAT];
   logic            neg_ff [DIV_LAT];
   logic            ovf_ff [DIV_LAT];

   // setup: magnitude, overflow check on the high part
   logic [S_W-1:0]   mag;
   logic [NUM_W-1:0] num;
   logic [DV_W-1:0]  hi_ext;
   logic [DV_W-1:0]  d_ext;

   always_comb begin
      mag    = s[S_W-1] ? S_W'(-s) : S_W'(s);
      num    = {mag, {FRAC_BITS{1'b0}}};
      hi_ext = DV_W'(num[NUM_W-1:Q_W]);
      d_ext  = DV_W'({root, 1'b0});
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= hi_ext;
      lo_ff[0]  <= num[Q_W-1:0];
      quo_ff[0] <= '0;
      d_ff[0]   <= d_ext;
      neg_ff[0] <= s[S_W-1];
      ovf_ff[0] <= (hi_ext >= d_ext);
   end

   for (genvar g = 1; g < DIV_LAT; g++) begin : g_stage
      logic [DV_W-1:0] rem_in;
      logic [Q_W-1:0]  lo_in;
      logic [Q_W-1:0]  quo_in;

      // two restoring steps
      always_comb begin
         rem_in = rem_ff[g-1];
         lo_in  = lo_ff[g-1];
         quo_in = quo_ff[g-1];
         for (int t = 0; t < DV_STEP; t++) begin
            if ((g - 1) * DV_STEP + t < Q_W) begin
               rem_in = {rem_in[DV_W-2:0], lo_in[Q_W-1]};
               lo_in  = lo_in << 1;
               if (rem_in >= d_ff[g-1]) begin
                  rem_in = rem_in - d_ff[g-1];
                  quo_in = {quo_in[Q_W-2:0], 1'b1};
               end else begin
                  quo_in = {quo_in[Q_W-2:0], 1'b0};
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[g] <= rem_in;
         lo_ff[g]  <= lo_in;
         quo_ff[g] <= quo_in;
         d_ff[g]   <= d_ff[g-1];
         neg_ff[g] <= neg_ff[g-1];
         ovf_ff[g] <= ovf_ff[g-1];
      end
   end

   // sign and saturation
   logic [Q_W-1:0] quo_last;
   always_comb begin
      quo_last = quo_ff[DIV_LAT-1];
      if (neg_ff[DIV_LAT-1]) begin
         if (ovf_ff[DIV_LAT-1] || (quo_last > Q_W'(QMIN))) begin
            q = QMIN;
         end else begin
            q = elem_type'(-quo_last);
         end
      end else begin
         if (ovf_ff[DIV_LAT-1] || quo_last[Q_W-1]) begin
            q = QMAX;
         end else begin
            q = elem_type'(quo_last);
         end
      end
   end

endmodule

`default_nettype wire
